>>> rtl/nia_pkg.sv
// nia_pkg: shared types and constants for the nullable integer arithmetic unit.
// No dependencies; every other file of the unit takes names from here.
`timescale 1ns / 1ps

package nia_pkg;

  // Default operand width
  localparam int unsigned DATA_WIDTH_DEF = 64;
  // Width of the payload fields on the ports
  localparam int unsigned PORT_WIDTH = 64;
  localparam int unsigned CMD_WIDTH  = 3;

  typedef enum logic [CMD_WIDTH-1:0] {
    CMD_ADD = 3'd0,
    CMD_SUB = 3'd1,
    CMD_MUL = 3'd2,
    CMD_DIV = 3'd3,
    CMD_REM = 3'd4
  } cmd_e_t;

  // Control word that travels down the pipeline with each item
  typedef struct packed {
    cmd_e_t cmd;
    logic   ok;   // result present
    logic   na;   // dividend negative
    logic   nb;   // divisor negative
  } ctrl_t;

endpackage

>>> rtl/nia_if.sv
// nia_if: valid/ready channel carrying operand items or result items.
// Depends on nia_pkg for field widths.
`timescale 1ns / 1ps

interface nia_in_if;
  logic                               valid;
  logic                               ready;
  logic [nia_pkg::CMD_WIDTH-1:0]      command;
  logic signed [nia_pkg::PORT_WIDTH-1:0] left_value;
  logic                               left_valid;
  logic signed [nia_pkg::PORT_WIDTH-1:0] right_value;
  logic                               right_valid;

  modport source (output valid, command, left_value, left_valid, right_value, right_valid,
                  input ready);
  modport sink   (input valid, command, left_value, left_valid, right_value, right_valid,
                  output ready);
endinterface

interface nia_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [nia_pkg::PORT_WIDTH-1:0] result_value;
  logic                               result_valid;

  modport source (output valid, result_value, result_valid, input ready);
  modport sink   (input valid, result_value, result_valid, output ready);
endinterface

>>> rtl/nullable_int_arith_unit_top.sv
// nullable_int_arith_unit_top: pipelined add/sub/mul/div/rem on nullable integers.
// Depends on nia_pkg and the channel interfaces in nia_if.sv.
`timescale 1ns / 1ps

// Usage
//   in_ch  : one operand pair per transfer: command, left/right value and their
//            valid marks. Values are read as signed DATA_WIDTH-bit words.
//   out_ch : one result per input transfer, in order: value (sign-extended to
//            64 bits, zero when null) and a valid mark.
//   A null operand, a zero divisor or an unknown command gives a null result.
//   A result passes an input register, one register per quotient bit of the
//   pipelined restoring divider and an output register before it is offered.
//   Add, subtract and multiply ride the same pipeline; the multiply is built
//   from three half-width partial products.
//   Throughput is one item per cycle while the receiver does not stall.
//   When the receiver stalls a valid result, the whole pipeline holds and
//   in_ch.ready falls; nothing is dropped or repeated.
//   Synchronous active-low reset clears all stage valid bits; the pipeline
//   is empty and ready on the first cycle after reset.
module nullable_int_arith_unit_top #(
  parameter int unsigned DATA_WIDTH = nia_pkg::DATA_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  nia_in_if.sink    in_ch,
  nia_out_if.source out_ch
);

  localparam int unsigned W = DATA_WIDTH;
  // Low half takes the extra bit on odd widths so the high-by-high term drops out
  localparam int unsigned H = (W + 1) / 2;

  logic en;
  logic out_valid_r;

  // Pipeline advances unless a finished result is held
  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  // ---------------- Input preparation ----------------
  logic [W-1:0] a_w, b_w, ua_c, ub_c;
  nia_pkg::ctrl_t ctrl_c;

  always_comb begin
    a_w        = in_ch.left_value[W-1:0];
    b_w        = in_ch.right_value[W-1:0];
    ctrl_c.cmd = nia_pkg::cmd_e_t'(in_ch.command);
    ctrl_c.na  = a_w[W-1];
    ctrl_c.nb  = b_w[W-1];
    ua_c       = a_w[W-1] ? (~a_w + 1'b1) : a_w;
    ub_c       = b_w[W-1] ? (~b_w + 1'b1) : b_w;
    ctrl_c.ok  = in_ch.left_valid && in_ch.right_valid;
    case (ctrl_c.cmd)
      nia_pkg::CMD_ADD, nia_pkg::CMD_SUB, nia_pkg::CMD_MUL: ;
      nia_pkg::CMD_DIV, nia_pkg::CMD_REM: begin
        if (b_w == '0) ctrl_c.ok = 1'b0;
      end
      default: ctrl_c.ok = 1'b0;
    endcase
  end

  // ---------------- Stage arrays ----------------
  logic           vld_r  [0:W];
  nia_pkg::ctrl_t ctrl_r [0:W];
  logic [W-1:0]   quo_r  [0:W];
  logic [W-1:0]   rem_r  [0:W];
  logic [W-1:0]   ub_r   [0:W];
  logic [W-1:0]   arith_r[2:W];
  logic [W-1:0]   a0_r, b0_r;

  // Stage 0: registered operands
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctrl_r[0] <= ctrl_c;
      quo_r[0]  <= ua_c;
      rem_r[0]  <= '0;
      ub_r[0]   <= ub_c;
      a0_r      <= a_w;
      b0_r      <= b_w;
    end
  end

  // ---------------- Add / subtract / multiply ----------------
  logic [W-1:0] al_x, ah_x, bl_x, bh_x;
  logic [W-1:0] pp0_nxt, pp1_nxt, pp2_nxt, addsub_nxt;
  logic [W-1:0] pp0_r, pp1_r, pp2_r, addsub_r;
  logic [W-1:0] arith2_nxt;

  always_comb begin
    al_x       = {{(W-H){1'b0}}, a0_r[H-1:0]};
    bl_x       = {{(W-H){1'b0}}, b0_r[H-1:0]};
    ah_x       = {{H{1'b0}}, a0_r[W-1:H]};
    bh_x       = {{H{1'b0}}, b0_r[W-1:H]};
    pp0_nxt    = al_x * bl_x;
    pp1_nxt    = al_x * bh_x;
    pp2_nxt    = ah_x * bl_x;
    addsub_nxt = (ctrl_r[0].cmd == nia_pkg::CMD_SUB) ? (a0_r - b0_r) : (a0_r + b0_r);
  end

  // Stage 1 side registers: partial products and the sum or difference
  always_ff @(posedge clk) begin
    if (en) begin
      pp0_r    <= pp0_nxt;
      pp1_r    <= pp1_nxt;
      pp2_r    <= pp2_nxt;
      addsub_r <= addsub_nxt;
    end
  end

  // Stage 2: recombine the product (cross terms shifted by half a word), or pass the sum or difference
  always_comb begin
    if (ctrl_r[1].cmd == nia_pkg::CMD_MUL) begin
      arith2_nxt = pp0_r + ((pp1_r + pp2_r) << H);
    end else begin
      arith2_nxt = addsub_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) arith_r[2] <= arith2_nxt;
  end

  genvar gk;
  generate
    for (gk = 3; gk <= W; gk++) begin : g_arith_dly
      always_ff @(posedge clk) begin
        if (en) arith_r[gk] <= arith_r[gk-1];
      end
    end
  endgenerate

  // ---------------- Restoring divider, one quotient bit per stage ----------------
  generate
    for (gk = 1; gk <= W; gk++) begin : g_div
      logic [W:0]   trial;
      logic [W:0]   diff;
      logic [W-1:0] quo_nxt, rem_nxt;

      always_comb begin
        trial = {rem_r[gk-1], quo_r[gk-1][W-1]};
        diff  = trial - {1'b0, ub_r[gk-1]};
        if (!diff[W]) begin
          rem_nxt = diff[W-1:0];
          quo_nxt = {quo_r[gk-1][W-2:0], 1'b1};
        end else begin
          rem_nxt = trial[W-1:0];
          quo_nxt = {quo_r[gk-1][W-2:0], 1'b0};
        end
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[gk] <= 1'b0;
        end else if (en) begin
          vld_r[gk] <= vld_r[gk-1];
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          ctrl_r[gk] <= ctrl_r[gk-1];
          ub_r[gk]   <= ub_r[gk-1];
          quo_r[gk]  <= quo_nxt;
          rem_r[gk]  <= rem_nxt;
        end
      end
    end
  endgenerate

  // ---------------- Output stage: sign fix-up and selection ----------------
  logic [W-1:0] res_c;
  logic [nia_pkg::PORT_WIDTH-1:0] res_value_r;
  logic res_ok_r;

  always_comb begin
    case (ctrl_r[W].cmd)
      nia_pkg::CMD_ADD, nia_pkg::CMD_SUB, nia_pkg::CMD_MUL: res_c = arith_r[W];
      nia_pkg::CMD_DIV:
        res_c = (ctrl_r[W].na ^ ctrl_r[W].nb) ? (~quo_r[W] + 1'b1) : quo_r[W];
      nia_pkg::CMD_REM:
        res_c = ctrl_r[W].na ? (~rem_r[W] + 1'b1) : rem_r[W];
      default: res_c = '0;
    endcase
    if (!ctrl_r[W].ok) res_c = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vld_r[W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_value_r <= nia_pkg::PORT_WIDTH'(signed'(res_c));
      res_ok_r    <= ctrl_r[W].ok;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.result_value = res_value_r;
  assign out_ch.result_valid = res_ok_r;

  // ---------------- Assertions ----------------
  a_null_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.result_valid) |-> (out_ch.result_value == '0))
    else $error("null result with non-zero value");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> vld_r[0])
    else $error("accepted item missing from first stage");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!en) |=> ($stable(vld_r[W]) && $stable(res_value_r)))
    else $error("pipeline moved during a stall");

endmodule

>>> bench/nullable_int_arith_unit_top_tb.sv
// Testbench for the nullable integer arithmetic unit: directed corner cases, then
// random operand pairs, checked in order against an in-bench arithmetic predictor.
// Depends on nia_pkg, nia_if.sv and the RTL top level.
`timescale 1ns / 1ps

module nullable_int_arith_unit_top_tb;

  localparam logic signed [63:0] MIN64 = 64'sh8000_0000_0000_0000;
  localparam logic signed [63:0] MAX64 = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 80;
  // Command codes with no operation behind them
  localparam logic [nia_pkg::CMD_WIDTH-1:0] CMD_RSVD_LO  = 3'd5;
  localparam logic [nia_pkg::CMD_WIDTH-1:0] CMD_RSVD_MID = 3'd6;
  localparam logic [nia_pkg::CMD_WIDTH-1:0] CMD_RSVD_HI  = 3'd7;

  typedef struct packed {
    logic [nia_pkg::CMD_WIDTH-1:0] cmd;
    logic signed [63:0]   lhs;
    logic                 lhs_ok;
    logic signed [63:0]   rhs;
    logic                 rhs_ok;
  } operands_t;

  typedef struct packed {
    logic signed [63:0] value;
    logic               present;
  } answer_t;

  logic clk;
  logic rst_n;
  nia_in_if  in_ch ();
  nia_out_if out_ch ();

  nullable_int_arith_unit_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  operands_t pending_ops[$];
  answer_t   awaited_answers[$];
  int        error_count;
  int        cycle_count;
  int        burst_left;
  int        gap_left;
  int        stall_phase;
  bit        stim_done;
  bit        hold_for_drain;

  // Arithmetic on the 64-bit two's complement word, null-propagating
  function automatic answer_t compute_answer(operands_t op);
    answer_t   ans;
    logic [63:0] mag_a;
    logic [63:0] mag_b;
    logic [63:0] q;
    logic [63:0] r;
    ans.value   = '0;
    ans.present = op.lhs_ok && op.rhs_ok;
    if (ans.present) begin
      mag_a = op.lhs[63] ? -op.lhs : op.lhs;
      mag_b = op.rhs[63] ? -op.rhs : op.rhs;
      case (op.cmd)
        nia_pkg::CMD_ADD: ans.value = op.lhs + op.rhs;
        nia_pkg::CMD_SUB: ans.value = op.lhs - op.rhs;
        nia_pkg::CMD_MUL: ans.value = op.lhs * op.rhs;
        nia_pkg::CMD_DIV, nia_pkg::CMD_REM: begin
          if (op.rhs == 64'sd0) begin
            ans.present = 1'b0;
          end else begin
            q = mag_a / mag_b;
            r = mag_a % mag_b;
            if (op.cmd == nia_pkg::CMD_DIV) ans.value = (op.lhs[63] != op.rhs[63]) ? -q : q;
            else                            ans.value = op.lhs[63] ? -r : r;
          end
        end
        default: ans.present = 1'b0;
      endcase
    end
    return ans;
  endfunction

  function automatic logic signed [63:0] pick_value();
    case ($urandom_range(0, 9))
      0: return MIN64;
      1: return MAX64;
      2: return 64'(signed'($urandom_range(0, 6)) - 3);
      3: return 64'(signed'($urandom_range(0, 2000)) - 1000);
      4: return {{32{1'b0}}, $urandom()};
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  task automatic queue_op(logic [nia_pkg::CMD_WIDTH-1:0] c, logic signed [63:0] a, logic av,
                          logic signed [63:0] b, logic bv);
    operands_t op;
    op = '{cmd: c, lhs: a, lhs_ok: av, rhs: b, rhs_ok: bv};
    pending_ops.push_back(op);
  endtask

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Stimulus: directed corners, then random pairs with one full drain midway
  initial begin
    logic [nia_pkg::CMD_WIDTH-1:0] c;
    stim_done      = 1'b0;
    hold_for_drain = 1'b0;
    rst_n          = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    queue_op(nia_pkg::CMD_ADD, MAX64, 1'b1, 64'sd1, 1'b1);
    queue_op(nia_pkg::CMD_ADD, MIN64, 1'b1, -64'sd1, 1'b1);
    queue_op(nia_pkg::CMD_SUB, MIN64, 1'b1, 64'sd1, 1'b1);
    queue_op(nia_pkg::CMD_SUB, 64'sd0, 1'b1, MIN64, 1'b1);
    queue_op(nia_pkg::CMD_MUL, MAX64, 1'b1, MAX64, 1'b1);
    queue_op(nia_pkg::CMD_MUL, MIN64, 1'b1, -64'sd1, 1'b1);
    queue_op(nia_pkg::CMD_DIV, MIN64, 1'b1, -64'sd1, 1'b1);
    queue_op(nia_pkg::CMD_REM, MIN64, 1'b1, -64'sd1, 1'b1);
    queue_op(nia_pkg::CMD_DIV, -64'sd7, 1'b1, 64'sd2, 1'b1);
    queue_op(nia_pkg::CMD_REM, -64'sd7, 1'b1, 64'sd2, 1'b1);
    queue_op(nia_pkg::CMD_REM, 64'sd7, 1'b1, -64'sd2, 1'b1);
    queue_op(nia_pkg::CMD_DIV, 64'sd5, 1'b1, 64'sd0, 1'b1);
    queue_op(nia_pkg::CMD_REM, 64'sd5, 1'b1, 64'sd0, 1'b1);
    queue_op(nia_pkg::CMD_ADD, 64'sd3, 1'b0, 64'sd4, 1'b1);
    queue_op(nia_pkg::CMD_MUL, 64'sd3, 1'b1, 64'sd4, 1'b0);
    queue_op(nia_pkg::CMD_DIV, 64'sd3, 1'b0, 64'sd0, 1'b0);
    queue_op(CMD_RSVD_LO, 64'sd1, 1'b1, 64'sd1, 1'b1);
    queue_op(CMD_RSVD_MID, -64'sd1, 1'b1, -64'sd1, 1'b1);
    queue_op(CMD_RSVD_HI, MIN64, 1'b1, MAX64, 1'b1);
    queue_op(nia_pkg::CMD_DIV, MAX64, 1'b1, MIN64, 1'b1);
    queue_op(nia_pkg::CMD_REM, MIN64, 1'b1, MAX64, 1'b1);
    for (int i = 0; i < 2000; i++) begin
      if (i == 1000) begin
        wait (pending_ops.size() == 0);
        hold_for_drain = 1'b1;
        wait (awaited_answers.size() == 0);
        hold_for_drain = 1'b0;
      end
      c = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(CMD_RSVD_LO, CMD_RSVD_HI))
                                       : 3'($urandom_range(nia_pkg::CMD_ADD, nia_pkg::CMD_REM));
      queue_op(c, pick_value(), $urandom_range(0, 9) != 0,
               pick_value(), $urandom_range(0, 9) != 0);
    end
    stim_done = 1'b1;
  end

  // Driver: bursts of transfers separated by random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid       <= 1'b0;
      in_ch.command     <= '0;
      in_ch.left_value  <= '0;
      in_ch.left_valid  <= 1'b0;
      in_ch.right_value <= '0;
      in_ch.right_valid <= 1'b0;
      burst_left        <= $urandom_range(1, 40);
      gap_left          <= 0;
    end else if (!in_ch.valid || in_ch.ready) begin
      // the item on the port leaves the queue at its transfer
      if (in_ch.valid) awaited_answers.push_back(compute_answer(pending_ops.pop_front()));
      if (gap_left > 0) begin
        gap_left    <= gap_left - 1;
        in_ch.valid <= 1'b0;
      end else if (pending_ops.size() > 0 && !hold_for_drain) begin
        in_ch.valid       <= 1'b1;
        in_ch.command     <= pending_ops[0].cmd;
        in_ch.left_value  <= pending_ops[0].lhs;
        in_ch.left_valid  <= pending_ops[0].lhs_ok;
        in_ch.right_value <= pending_ops[0].rhs;
        in_ch.right_valid <= pending_ops[0].rhs_ok;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left   <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver stall pattern: phases of always-ready, random and heavy back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_phase  <= 0;
    end else begin
      stall_phase <= (stall_phase + 1) % 600;
      if (stall_phase < 200)      out_ch.ready <= 1'b1;
      else if (stall_phase < 400) out_ch.ready <= ($urandom_range(0, 1) == 1);
      else                        out_ch.ready <= ($urandom_range(0, 4) == 0);
    end
  end

  // Monitor: compare every result transfer with the oldest expectation
  always @(posedge clk) begin
    answer_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (awaited_answers.size() == 0) begin
        $display("%0t: unexpected result value=%h valid=%b", $time,
                 out_ch.result_value, out_ch.result_valid);
        error_count <= error_count + 1;
      end else begin
        want = awaited_answers.pop_front();
        if (out_ch.result_value !== want.value || out_ch.result_valid !== want.present) begin
          $display("%0t: mismatch expected value=%h valid=%b actual value=%h valid=%b",
                   $time, want.value, want.present, out_ch.result_value,
                   out_ch.result_valid);
          error_count <= error_count + 1;
        end
      end
    end
  end

  // End of run and timeout
  initial begin
    error_count = 0;
    cycle_count = 0;
    fork
      begin
        wait (stim_done && pending_ops.size() == 0 && !in_ch.valid);
        wait (awaited_answers.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
      end
      begin
        while (cycle_count < CYCLE_LIMIT) begin
          @(posedge clk);
          cycle_count++;
        end
        error_count = error_count + 1;
        $display("%0t: timeout", $time);
      end
    join_any
    if (error_count == 0 && awaited_answers.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
